// ===== hdl/ffba_pkg.sv =====
// Package for the first-fit block allocator: widths, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int MaxBlocksDefault = 64;
    localparam logic [31:0] HeapBytesDefault = 32'd33554432;
    localparam logic [6:0] HeaderBytesDefault = 7'd16;

    localparam logic [1:0] StatusDone = 2'd0;
    localparam logic [1:0] StatusAllocFail = 2'd1;
    localparam logic [1:0] StatusBadRelease = 2'd2;

    localparam logic ActionAlloc = 1'b0;
    localparam logic ActionRelease = 1'b1;

    localparam logic RegHeap = 1'b0;
    localparam logic RegHeader = 1'b1;

    // Table entry as stored in the RAM: start, length, taken flag.
    localparam int EntryWidth = 65;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       init;        // table back to one free block
        logic       take_item;   // latch the input word, cursor to zero
        logic [1:0] rd_sel;      // table read address select
        logic       wr_en;
        logic [2:0] wr_sel;      // what to write and where
        logic       cur_inc;
        logic       sh_top;      // shift pointer = count - 1
        logic       sh_next2;    // shift pointer = cursor + 2
        logic       sh_next1;    // shift pointer = cursor + 1
        logic       sh_inc;
        logic       sh_dec;
        logic       hold_scan;   // capture read data into scan register
        logic       hold_nb;     // capture read data into neighbor register
        logic       scan_merge;  // scan length += neighbor length
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_result;
        logic [1:0] res_status;
    } ffba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic zero_size;
        logic scan_end;      // cursor == count
        logic fits;          // scan entry free and longer than need1
        logic splits;        // longer than need2 and table not full
        logic rel_hit;       // scan entry taken and address matches
        logic nb_free;       // neighbor register free
        logic has_next;      // cursor + 1 < count
        logic has_prev;      // cursor > 0
        logic up_done;       // shift pointer back at the cursor
        logic dn_done;       // shift pointer reached the count
    } ffba_sts_t;

    localparam logic [2:0] WrCurTaken = 3'd0;  // cur entry taken, need1 length on a split
    localparam logic [2:0] WrRemain = 3'd1;    // remainder at cur+1
    localparam logic [2:0] WrShiftUp = 3'd2;   // read data to shift+1
    localparam logic [2:0] WrCurFree = 3'd3;   // cur entry freed, merged length
    localparam logic [2:0] WrShiftDn = 3'd4;   // read data to shift-1
    localparam logic [2:0] WrPrevMerge = 3'd5; // prev entry with merged length
    localparam logic [2:0] WrInit = 3'd6;      // entry 0 whole heap

    localparam logic [1:0] RdCur = 2'd0;
    localparam logic [1:0] RdShift = 2'd1;
    localparam logic [1:0] RdNext = 2'd2;
    localparam logic [1:0] RdPrev = 2'd3;

endpackage

// ===== hdl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator with coalescing.
// Depends on ffba_pkg, ffba_ctrl, ffba_datapath and ffba_ram.
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata {release_addr,request_size,action}
//  m_axis    out        m_axis_tvalid/tready    tdata {status,result_addr}
//  cfg       in         cfg_we                  cfg_index, cfg_data
//
// An item scans table entries in turn (issue read, read data lands, test) and
// moves entries one at a time on a split or merge (read, then write), the
// registered table RAM read setting the pace. A zero size answers without a scan.
// Reset spends one cycle writing the initial free block before input is
// taken. A stalled result holds the block until it is taken.
`timescale 1ns / 1ps
module first_fit_block_allocator #(
    parameter int MaxBlocks = ffba_pkg::MaxBlocksDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // action, request_size, release_addr, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_addr, status, pad
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] heap_reg;
    logic [6:0]  header_reg;
    logic [31:0] init_heap;
    logic [31:0] res_addr;
    logic [1:0]  res_status;
    ffba_pkg::ffba_cmd_t cmd;
    ffba_pkg::ffba_sts_t sts;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= ffba_pkg::HeapBytesDefault;
            header_reg <= ffba_pkg::HeaderBytesDefault;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ffba_pkg::RegHeap)
            begin
                heap_reg <= cfg_data;
            end
            else
            begin
                header_reg <= cfg_data[6:0];
            end
        end
    end

    // Table re-init on a heap write uses the new size
    assign init_heap = (cfg_we && cfg_index == ffba_pkg::RegHeap) ? cfg_data : heap_reg;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_we),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffba_datapath #(.MaxBlocks(MaxBlocks)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .heap_bytes  (init_heap),
        .header_bytes(header_reg),
        .in_action   (s_axis_tdata[0]),
        .in_size     (s_axis_tdata[32:1]),
        .in_addr     (s_axis_tdata[64:33]),
        .res_addr    (res_addr),
        .res_status  (res_status)
    );

    assign m_axis_tdata = {6'd0, res_status, res_addr};

    // A result is never shown while a new word is being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // Failed allocates and bad releases report a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[33:32] != ffba_pkg::StatusDone)
            |-> m_axis_tdata[31:0] == 32'd0)
        else $error("nonzero address on failure");

    // A stalled result word holds steady
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

endmodule

// ===== hdl/ffba_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ffba_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ffba_datapath.sv =====
// Datapath: block table RAM, scan cursor, count, size compares and result.
// Depends on ffba_pkg and ffba_ram.
`timescale 1ns / 1ps
module ffba_datapath #(
    parameter int MaxBlocks = ffba_pkg::MaxBlocksDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffba_pkg::ffba_cmd_t cmd,
    output ffba_pkg::ffba_sts_t sts,
    input  logic [31:0]         heap_bytes,
    input  logic [6:0]          header_bytes,
    input  logic                in_action,
    input  logic [31:0]         in_size,
    input  logic [31:0]         in_addr,
    output logic [31:0]         res_addr,
    output logic [1:0]          res_status
);

    localparam int IdxW = $clog2(MaxBlocks);
    localparam int CntW = $clog2(MaxBlocks + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MaxBlocks);

    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0] cur_reg, cur_next;
    logic [CntW-1:0] sh_reg, sh_next;
    logic            act_reg;
    logic [31:0]     size_reg, addr_reg;
    logic [32:0]     need1, need2;
    logic [31:0]     sc_start_reg, sc_len_reg;
    logic            sc_taken_reg;
    logic [31:0]     nb_start_reg, nb_len_reg;
    logic            nb_taken_reg;
    logic [31:0]     res_addr_reg;
    logic [1:0]      res_status_reg;

    logic            we;
    logic [IdxW-1:0] waddr, raddr;
    logic [ffba_pkg::EntryWidth-1:0] wdata, rdata;
    logic [CntW-1:0] rd_idx, wr_idx;

    ffba_ram #(.Width(ffba_pkg::EntryWidth), .Depth(MaxBlocks)) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign need1 = {1'b0, size_reg} + 33'(header_bytes);
    assign need2 = need1 + 33'(header_bytes);

    // Read address selection
    always_comb
    begin
        case (cmd.rd_sel)
            ffba_pkg::RdCur:   rd_idx = cur_reg;
            ffba_pkg::RdShift: rd_idx = sh_reg;
            ffba_pkg::RdNext:  rd_idx = cur_reg + CntW'(1);
            ffba_pkg::RdPrev:  rd_idx = cur_reg - CntW'(1);
            default:           rd_idx = cur_reg;
        endcase
    end
    assign raddr = rd_idx[IdxW-1:0];

    // Write address and data selection
    always_comb
    begin
        we = cmd.wr_en;
        case (cmd.wr_sel)
            ffba_pkg::WrCurTaken:
            begin
                wr_idx = cur_reg;
                wdata = {sc_start_reg,
                         (sts.splits ? need1[31:0] : sc_len_reg), 1'b1};
            end
            ffba_pkg::WrRemain:
            begin
                wr_idx = cur_reg + CntW'(1);
                wdata = {sc_start_reg + need1[31:0], sc_len_reg - need1[31:0], 1'b0};
            end
            ffba_pkg::WrShiftUp:
            begin
                wr_idx = sh_reg + CntW'(1);
                wdata = rdata;
            end
            ffba_pkg::WrCurFree:
            begin
                wr_idx = cur_reg;
                wdata = {sc_start_reg, sc_len_reg, 1'b0};
            end
            ffba_pkg::WrShiftDn:
            begin
                wr_idx = sh_reg - CntW'(1);
                wdata = rdata;
            end
            ffba_pkg::WrPrevMerge:
            begin
                wr_idx = cur_reg - CntW'(1);
                wdata = {nb_start_reg, nb_len_reg + sc_len_reg, 1'b0};
            end
            ffba_pkg::WrInit:
            begin
                wr_idx = '0;
                wdata = {32'd0, heap_bytes, 1'b0};
            end
            default:
            begin
                wr_idx = cur_reg;
                wdata = {sc_start_reg, sc_len_reg, sc_taken_reg};
            end
        endcase
    end
    assign waddr = wr_idx[IdxW-1:0];

    // Status toward the controller
    always_comb
    begin
        sts.is_release = act_reg;
        sts.zero_size = (size_reg == 32'd0);
        sts.scan_end = (cur_reg == cnt_reg);
        sts.fits = !sc_taken_reg && ({1'b0, sc_len_reg} > need1);
        sts.splits = ({1'b0, sc_len_reg} > need2) && (cnt_reg < CntMax);
        sts.rel_hit = sc_taken_reg &&
            ({1'b0, sc_start_reg} + 33'(header_bytes) == {1'b0, addr_reg});
        sts.nb_free = !nb_taken_reg;
        sts.has_next = ({1'b0, cur_reg} + (CntW+1)'(1)) < {1'b0, cnt_reg};
        sts.has_prev = (cur_reg != '0);
        sts.up_done = (sh_reg == cur_reg);
        sts.dn_done = (sh_reg == cnt_reg);
    end

    // Control registers: count and cursors
    always_comb
    begin
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        sh_next = sh_reg;
        if (cmd.init)
        begin
            cnt_next = CntW'(1);
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CntW'(1);
        end
        if (cmd.take_item)
        begin
            cur_next = '0;
        end
        else if (cmd.cur_inc)
        begin
            cur_next = cur_reg + CntW'(1);
        end
        if (cmd.sh_top)
        begin
            sh_next = cnt_reg - CntW'(1);
        end
        else if (cmd.sh_next2)
        begin
            sh_next = cur_reg + CntW'(2);
        end
        else if (cmd.sh_next1)
        begin
            sh_next = cur_reg + CntW'(1);
        end
        else if (cmd.sh_inc)
        begin
            sh_next = sh_reg + CntW'(1);
        end
        else if (cmd.sh_dec)
        begin
            sh_next = sh_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CntW'(1);
            cur_reg <= '0;
            sh_reg <= '0;
            res_status_reg <= ffba_pkg::StatusDone;
            res_addr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            cur_reg <= cur_next;
            sh_reg <= sh_next;
            if (cmd.set_result)
            begin
                res_status_reg <= cmd.res_status;
                res_addr_reg <= (cmd.res_status == ffba_pkg::StatusDone && !act_reg)
                    ? sc_start_reg + 32'(header_bytes) : 32'd0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            act_reg <= in_action;
            size_reg <= in_size;
            addr_reg <= in_addr;
        end
        if (cmd.hold_scan)
        begin
            {sc_start_reg, sc_len_reg, sc_taken_reg} <= rdata;
        end
        else if (cmd.scan_merge)
        begin
            sc_len_reg <= sc_len_reg + nb_len_reg;
        end
        if (cmd.hold_nb)
        begin
            {nb_start_reg, nb_len_reg, nb_taken_reg} <= rdata;
        end
    end

    assign res_addr = res_addr_reg;
    assign res_status = res_status_reg;

endmodule

// ===== hdl/ffba_ctrl.sv =====
// Controller state machine: scan, split shift, release merge, result.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ffba_pkg::ffba_sts_t sts,
    output ffba_pkg::ffba_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_INIT,     // write entry 0 after reset
        S_IDLE,
        S_RD,       // issue read of cursor entry
        S_RDW,      // read data lands
        S_TEST,
        S_UP_RD,    // shift up: read entry at shift pointer
        S_UP_WR,
        S_TAKE,
        S_REMAIN,
        S_NX_RD,
        S_NX_RDW,
        S_NX_TEST,
        S_DN_RD,    // shift down after entry removal
        S_DN_WR,
        S_PV_RD,
        S_PV_RDW,
        S_PV_TEST,
        S_FREE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;  // 0 merging next, 1 merging prev

    assign in_ready = (state_reg == S_IDLE) && !cfg_write;
    assign out_valid = (state_reg == S_OUT);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd = '0;
        cmd.rd_sel = ffba_pkg::RdCur;
        cmd.wr_sel = ffba_pkg::WrCurTaken;
        cmd.res_status = ffba_pkg::StatusDone;
        if (cfg_write)
        begin
            cmd.init = 1'b1;
            cmd.wr_en = 1'b1;
            cmd.wr_sel = ffba_pkg::WrInit;
        end
        case (state_reg)
            S_INIT:
            begin
                cmd.init = 1'b1;
                cmd.wr_en = 1'b1;
                cmd.wr_sel = ffba_pkg::WrInit;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.take_item = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (!sts.is_release && sts.zero_size)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ffba_pkg::StatusAllocFail;
                    state_next = S_OUT;
                end
                else if (sts.scan_end)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = sts.is_release ? ffba_pkg::StatusBadRelease
                                                    : ffba_pkg::StatusAllocFail;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RDW;
                end
            end
            S_RDW:
            begin
                cmd.hold_scan = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (sts.is_release ? sts.rel_hit : sts.fits)
                begin
                    if (sts.is_release)
                    begin
                        phase_next = 1'b0;
                        state_next = S_NX_RD;
                    end
                    else if (sts.splits)
                    begin
                        cmd.sh_top = 1'b1;
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        state_next = S_TAKE;
                    end
                end
                else
                begin
                    cmd.cur_inc = 1'b1;
                    state_next = S_RD;
                end
            end
            // Move entries cur+1..count-1 up by one, from the top down
            S_UP_RD:
            begin
                if (sts.up_done)
                begin
                    state_next = S_TAKE;
                end
                else
                begin
                    cmd.rd_sel = ffba_pkg::RdShift;
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = ffba_pkg::WrShiftUp;
                cmd.sh_dec = 1'b1;
                state_next = S_UP_RD;
            end
            S_TAKE:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = ffba_pkg::WrCurTaken;
                if (sts.splits)
                begin
                    state_next = S_REMAIN;
                end
                else
                begin
                    cmd.set_result = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_REMAIN:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = ffba_pkg::WrRemain;
                cmd.cnt_inc = 1'b1;
                cmd.set_result = 1'b1;
                state_next = S_OUT;
            end
            // Release: try the next neighbor first
            S_NX_RD:
            begin
                if (sts.has_next)
                begin
                    cmd.rd_sel = ffba_pkg::RdNext;
                    state_next = S_NX_RDW;
                end
                else
                begin
                    state_next = S_PV_RD;
                end
            end
            S_NX_RDW:
            begin
                cmd.hold_nb = 1'b1;
                state_next = S_NX_TEST;
            end
            S_NX_TEST:
            begin
                if (sts.nb_free)
                begin
                    cmd.scan_merge = 1'b1;
                    cmd.sh_next2 = 1'b1;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_PV_RD;
                end
            end
            // Close the gap left by a removed entry
            S_DN_RD:
            begin
                if (sts.dn_done)
                begin
                    cmd.cnt_dec = 1'b1;
                    if (phase_reg)
                    begin
                        cmd.set_result = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_PV_RD;
                    end
                end
                else
                begin
                    cmd.rd_sel = ffba_pkg::RdShift;
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = ffba_pkg::WrShiftDn;
                cmd.sh_inc = 1'b1;
                state_next = S_DN_RD;
            end
            // Then the previous neighbor
            S_PV_RD:
            begin
                if (sts.has_prev)
                begin
                    cmd.rd_sel = ffba_pkg::RdPrev;
                    state_next = S_PV_RDW;
                end
                else
                begin
                    state_next = S_FREE;
                end
            end
            S_PV_RDW:
            begin
                cmd.hold_nb = 1'b1;
                state_next = S_PV_TEST;
            end
            S_PV_TEST:
            begin
                if (sts.nb_free)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_sel = ffba_pkg::WrPrevMerge;
                    cmd.sh_next1 = 1'b1;
                    phase_next = 1'b1;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = ffba_pkg::WrCurFree;
                cmd.set_result = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the first-fit block allocator: drives allocate and release words,
// predicts results with an own heap table model and checks every result word.
// Depends on ffba_pkg and first_fit_block_allocator.
`timescale 1ns / 1ps
module tb_top;

    localparam int TblDepth = ffba_pkg::MaxBlocksDefault;

    typedef struct packed {
        logic [31:0] release_addr;
        logic [31:0] request_size;
        logic        action;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_addr;
    } alloc_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    // Predictor state
    logic [31:0] heap_len;
    logic [6:0]  hdr_len;
    logic [31:0] blk_start [TblDepth];
    logic [31:0] blk_len [TblDepth];
    logic        blk_taken [TblDepth];
    int          blk_cnt;

    alloc_req_t  pending_words[$];
    alloc_rsp_t  expected_rsp[$];
    logic [31:0] live_addrs[$];
    int          fail_count = 0;
    int          send_idle_pct = 21;
    int          recv_idle_pct = 83;
    bit          hold_send = 1'b0;

    first_fit_block_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void table_clear();
        for (int i = 0; i < TblDepth; i++)
        begin
            blk_start[i] = '0;
            blk_len[i] = '0;
            blk_taken[i] = 1'b0;
        end
        blk_len[0] = heap_len;
        blk_cnt = 1;
    endfunction

    function automatic void drop_entry(int idx);
        for (int k = idx; k + 1 < blk_cnt; k++)
        begin
            blk_start[k] = blk_start[k + 1];
            blk_len[k] = blk_len[k + 1];
            blk_taken[k] = blk_taken[k + 1];
        end
        blk_cnt--;
    endfunction

    // Heap table update for one request word
    function automatic alloc_rsp_t heap_predict(alloc_req_t req);
        alloc_rsp_t rsp;
        logic [32:0] need1;
        logic [32:0] need2;
        int i;
        rsp.result_addr = '0;
        rsp.status = ffba_pkg::StatusAllocFail;
        if (req.action == ffba_pkg::ActionAlloc)
        begin
            need1 = {1'b0, req.request_size} + 33'(hdr_len);
            need2 = need1 + 33'(hdr_len);
            if (req.request_size != 0)
            begin
                for (i = 0; i < blk_cnt; i++)
                begin
                    if (blk_taken[i] || {1'b0, blk_len[i]} <= need1)
                        continue;
                    if ({1'b0, blk_len[i]} > need2 && blk_cnt < TblDepth)
                    begin
                        for (int k = blk_cnt; k > i + 1; k--)
                        begin
                            blk_start[k] = blk_start[k - 1];
                            blk_len[k] = blk_len[k - 1];
                            blk_taken[k] = blk_taken[k - 1];
                        end
                        blk_start[i + 1] = blk_start[i] + need1[31:0];
                        blk_len[i + 1] = blk_len[i] - need1[31:0];
                        blk_taken[i + 1] = 1'b0;
                        blk_len[i] = need1[31:0];
                        blk_cnt++;
                    end
                    blk_taken[i] = 1'b1;
                    rsp.result_addr = blk_start[i] + 32'(hdr_len);
                    rsp.status = ffba_pkg::StatusDone;
                    break;
                end
            end
        end
        else
        begin
            rsp.status = ffba_pkg::StatusBadRelease;
            for (i = 0; i < blk_cnt; i++)
                if (blk_taken[i] && ({1'b0, blk_start[i]} + 33'(hdr_len))
                        == {1'b0, req.release_addr})
                    break;
            if (i < blk_cnt)
            begin
                rsp.status = ffba_pkg::StatusDone;
                blk_taken[i] = 1'b0;
                if (i + 1 < blk_cnt && !blk_taken[i + 1])
                begin
                    blk_len[i] += blk_len[i + 1];
                    drop_entry(i + 1);
                end
                if (i > 0 && !blk_taken[i - 1])
                begin
                    blk_len[i - 1] += blk_len[i];
                    drop_entry(i);
                end
            end
        end
        return rsp;
    endfunction

    // Driver: one word from the pending queue, predicted on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_rsp.push_back(heap_predict(alloc_req_t'(s_axis_tdata[64:0])));
                void'(pending_words.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_words.size() > 0
                    && !hold_send && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {7'b0, pending_words[0]};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare result words with the oldest prediction
    always @(posedge clk)
    begin
        alloc_rsp_t got;
        alloc_rsp_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = alloc_rsp_t'(m_axis_tdata[33:0]);
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected word", {30'b0, got.status}, '0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got.result_addr !== want.result_addr)
                        report_mismatch("result_addr", got.result_addr, want.result_addr);
                    else if (got.status == ffba_pkg::StatusDone
                             && want.status == ffba_pkg::StatusDone
                             && want.result_addr != 0)
                        live_addrs.push_back(want.result_addr);
                    if (got.status !== want.status)
                        report_mismatch("status", {30'b0, got.status}, {30'b0, want.status});
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Wait until all queued words are sent and every result has come back
    task automatic drain();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ffba_pkg::RegHeap)
            heap_len = val;
        else
            hdr_len = val[6:0];
        table_clear();
    endtask

    function automatic void queue_alloc(logic [31:0] sz);
        pending_words.push_back(alloc_req_t'{release_addr: $urandom(), request_size: sz,
                                             action: ffba_pkg::ActionAlloc});
    endfunction

    function automatic void queue_release(logic [31:0] addr);
        pending_words.push_back(alloc_req_t'{release_addr: addr, request_size: $urandom(),
                                             action: ffba_pkg::ActionRelease});
    endfunction

    // Mostly well-formed alloc/free traffic on live addresses, plus noise
    task automatic random_phase(int n, int max_sz);
        int pick;
        for (int j = 0; j < n; j++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_alloc($urandom_range(max_sz, 1));
            else if (pick < 85 && live_addrs.size() != 0)
            begin
                pick = $urandom_range(live_addrs.size() - 1);
                queue_release(live_addrs[pick]);
                live_addrs.delete(pick);
            end
            else if (pick < 92)
                queue_alloc($urandom());
            else
                queue_release($urandom());
            if (j % 50 == 49)
            begin
                // hold off until the allocator has caught up
                while (pending_words.size() != 0) @(posedge clk);
                hold_send = 1'b1;
                while (expected_rsp.size() != 0 || s_axis_tvalid) @(posedge clk);
                hold_send = 1'b0;
            end
        end
    endtask

    initial
    begin
        heap_len = ffba_pkg::HeapBytesDefault;
        hdr_len = ffba_pkg::HeaderBytesDefault;
        table_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero size, oversize, bad and double release
        queue_alloc(32'd0);
        queue_alloc(32'hFFFF_FFFF);
        queue_alloc(32'd1);
        queue_alloc(32'd100);
        queue_release(32'd16);
        queue_release(32'd16);
        queue_release(32'hFFFF_FFFF);
        queue_release(32'd0);
        queue_alloc(32'd33554432 - 32'd33);
        queue_alloc(32'd33554432 - 32'd16);
        for (int j = 0; j < 8; j++)
            queue_alloc(32'd8);
        drain();
        live_addrs.delete();

        // Tiny heap, zero header, table fill-up
        write_reg(ffba_pkg::RegHeap, 32'd10);
        write_reg(ffba_pkg::RegHeader, 32'd0);
        queue_alloc(32'd9);
        queue_alloc(32'd1);
        queue_release(32'd0);
        drain();
        live_addrs.delete();
        write_reg(ffba_pkg::RegHeap, 32'hFFFF_FFFF);
        write_reg(ffba_pkg::RegHeader, 32'd64);
        for (int j = 0; j < 70; j++)
            queue_alloc($urandom_range(200, 1));
        random_phase(150, 300);
        drain();
        live_addrs.delete();

        send_idle_pct = 83;
        recv_idle_pct = 21;
        write_reg(ffba_pkg::RegHeap, 32'd64);
        write_reg(ffba_pkg::RegHeader, 32'd1);
        random_phase(150, 40);
        drain();
        live_addrs.delete();
        write_reg(ffba_pkg::RegHeap, 32'd4096);
        write_reg(ffba_pkg::RegHeader, 32'd7);
        random_phase(200, 500);
        drain();
        live_addrs.delete();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(ffba_pkg::RegHeap, ffba_pkg::HeapBytesDefault);
        write_reg(ffba_pkg::RegHeader, 32'(ffba_pkg::HeaderBytesDefault));
        random_phase(200, 1 << 20);
        drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_datapath.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator.sv
dv/tb_top.sv
